@@ design/sktu_pkg.sv @@
// ----------------------------------------------------------------------------
// Session key table package
// Shared types, codes and defaults for the session key table upsert block.
// ----------------------------------------------------------------------------
package sktu_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int SLOT_W            = 6;
  localparam int Q_DEPTH           = 2;

  typedef enum logic [2:0] {
    OUT_APPENDED  = 3'd0,
    OUT_REPLACED  = 3'd1,
    OUT_REJECTED  = 3'd2,
    OUT_KEPT_TIE  = 3'd3,
    OUT_DUPLICATE = 3'd4,
    OUT_FULL      = 3'd5
  } outcome_t;

  // Classification made by the search front end.
  typedef enum logic [1:0] {
    CLS_MATCH  = 2'd0,
    CLS_APPEND = 2'd1,
    CLS_FULL   = 2'd2
  } cls_t;

  typedef enum logic {
    F_IDLE = 1'b0,
    F_SCAN = 1'b1
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_EVAL = 2'd1
  } back_state_t;

  typedef struct packed {
    logic [15:0] host;
    logic [31:0] stamp_seconds;
    logic [19:0] stamp_micros;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } in_req_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
  } out_res_t;

  // Stored part of an entry besides the host id.
  typedef struct packed {
    logic [31:0] seconds;
    logic [19:0] micros;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } entry_t;

  typedef struct packed {
    cls_t    cls;
    in_req_t req;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/sktu_front.sv @@
// ----------------------------------------------------------------------------
// Session key table search front end
// Holds the host ids and fill count, scans filled slots one per cycle while the queue
// is not full, and classifies each request as match, append or full.
// ----------------------------------------------------------------------------
module sktu_front #(
  parameter int TABLE_ENTRIES = sktu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  sktu_pkg::in_req_t  in_req,
  input  sktu_pkg::q_stat_t  q_stat,
  output logic               push,
  output sktu_pkg::q_entry_t push_entry,
  output logic [$clog2(TABLE_ENTRIES)-1:0] push_slot,
  output logic               front_busy
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int FW = $clog2(TABLE_ENTRIES + 1);

  sktu_pkg::front_state_t state_r, state_nxt;
  sktu_pkg::in_req_t      req_r;
  logic [FW-1:0]          idx_r, idx_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pend_idx_r, pend_idx_nxt;
  logic [15:0]            host_q_r;
  logic [15:0]            host_mem [TABLE_ENTRIES];

  logic hit, more, room, decide, rd_en, host_we;

  always_comb begin
    hit    = pend_r && (host_q_r == req_r.host);
    more   = idx_r < fill_r;
    room   = fill_r < FW'(TABLE_ENTRIES);
    decide = (state_r == sktu_pkg::F_SCAN) && !q_stat.full && (hit || !more);
    rd_en  = (state_r == sktu_pkg::F_SCAN) && !q_stat.full && !hit && more;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sktu_pkg::F_IDLE: if (accept) state_nxt = sktu_pkg::F_SCAN;
      sktu_pkg::F_SCAN: if (decide) state_nxt = sktu_pkg::F_IDLE;
      default:          state_nxt = sktu_pkg::F_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    push             = decide;
    push_entry.req   = req_r;
    push_entry.cls   = sktu_pkg::CLS_FULL;
    push_slot        = fill_r[AW-1:0];
    front_busy       = (state_r != sktu_pkg::F_IDLE);
    idx_nxt          = idx_r;
    pend_nxt         = pend_r;
    pend_idx_nxt     = pend_idx_r;
    fill_nxt         = fill_r;
    host_we          = 1'b0;
    if (hit) begin
      push_entry.cls = sktu_pkg::CLS_MATCH;
      push_slot      = pend_idx_r;
    end else if (room) begin
      push_entry.cls = sktu_pkg::CLS_APPEND;
    end
    case (state_r)
      sktu_pkg::F_IDLE: begin
        if (accept) begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      sktu_pkg::F_SCAN: begin
        if (!q_stat.full) begin
          // The read issued now is compared against the request next cycle.
          pend_nxt     = rd_en;
          pend_idx_nxt = idx_r[AW-1:0];
          if (rd_en) idx_nxt = idx_r + FW'(1);
          if (decide && push_entry.cls == sktu_pkg::CLS_APPEND) begin
            host_we  = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sktu_pkg::F_IDLE;
      idx_r   <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (accept && state_r == sktu_pkg::F_IDLE) req_r <= in_req;
  end

  always_ff @(posedge clk) begin
    if (host_we) host_mem[fill_r[AW-1:0]] <= req_r.host;
    if (rd_en)   host_q_r <= host_mem[idx_r[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.cls == sktu_pkg::CLS_APPEND) |=> fill_r == $past(fill_r) + FW'(1))
    else $error("append did not advance the fill count");
`endif

endmodule

@@ design/sktu_queue.sv @@
// ----------------------------------------------------------------------------
// Session key table request queue
// Short FIFO of classified requests between the search front and the
// update back end.
// ----------------------------------------------------------------------------
module sktu_queue #(
  parameter int AW = $clog2(sktu_pkg::TABLE_ENTRIES_DEF)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sktu_pkg::q_entry_t push_entry,
  input  logic [AW-1:0]      push_slot,
  input  logic               pop,
  output sktu_pkg::q_entry_t head_entry,
  output logic [AW-1:0]      head_slot,
  output sktu_pkg::q_stat_t  q_stat
);

  localparam int PW = (sktu_pkg::Q_DEPTH > 1) ? $clog2(sktu_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(sktu_pkg::Q_DEPTH + 1);

  sktu_pkg::q_entry_t entry_r [sktu_pkg::Q_DEPTH];
  logic [AW-1:0]      slot_r  [sktu_pkg::Q_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  always_comb begin
    q_stat.full  = (count_r == CW'(sktu_pkg::Q_DEPTH));
    q_stat.empty = (count_r == '0);
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    head_entry   = entry_r[rd_ptr_r];
    head_slot    = slot_r[rd_ptr_r];
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    count_nxt    = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(sktu_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(sktu_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
      slot_r[wr_ptr_r]  <= push_slot;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("request pushed into a full queue");
`endif

endmodule

@@ design/sktu_back.sv @@
// ----------------------------------------------------------------------------
// Session key table update back end
// Holds timestamps and keys, resolves matched requests by timestamp and key
// order, writes the table and drives the result strobe.
// ----------------------------------------------------------------------------
module sktu_back #(
  parameter int TABLE_ENTRIES = sktu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sktu_pkg::q_stat_t  q_stat,
  input  sktu_pkg::q_entry_t head_entry,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] head_slot,
  output logic               pop,
  output logic               back_busy,
  output logic               out_valid,
  output sktu_pkg::out_res_t out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = sktu_pkg::SLOT_W;

  sktu_pkg::back_state_t state_r, state_nxt;
  sktu_pkg::q_entry_t    cur_r;
  logic [AW-1:0]         cur_slot_r;
  sktu_pkg::entry_t      ent_q_r;
  sktu_pkg::entry_t      ent_mem [TABLE_ENTRIES];
  sktu_pkg::entry_t      wr_data;
  logic                  out_valid_r, out_valid_nxt;
  sktu_pkg::out_res_t    out_data_r, out_data_nxt;
  sktu_pkg::outcome_t    outcome;
  logic                  we;
  logic [51:0]           in_ts, st_ts;
  logic [127:0]          in_key, st_key;
  logic [SW+AW-1:0]      slot_wide;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sktu_pkg::B_IDLE: if (!q_stat.empty) state_nxt = sktu_pkg::B_EVAL;
      sktu_pkg::B_EVAL: state_nxt = sktu_pkg::B_IDLE;
      default:          state_nxt = sktu_pkg::B_IDLE;
    endcase
  end

  // Resolution of the current request
  always_comb begin
    in_ts   = {cur_r.req.stamp_seconds, cur_r.req.stamp_micros};
    st_ts   = {ent_q_r.seconds, ent_q_r.micros};
    in_key  = {cur_r.req.key_upper, cur_r.req.key_lower};
    st_key  = {ent_q_r.key_upper, ent_q_r.key_lower};
    wr_data = '{seconds:   cur_r.req.stamp_seconds,
                micros:    cur_r.req.stamp_micros,
                key_upper: cur_r.req.key_upper,
                key_lower: cur_r.req.key_lower};
    outcome = sktu_pkg::OUT_FULL;
    we      = 1'b0;
    case (cur_r.cls)
      sktu_pkg::CLS_APPEND: begin
        outcome = sktu_pkg::OUT_APPENDED;
        we      = 1'b1;
      end
      sktu_pkg::CLS_MATCH: begin
        // On equal timestamps the smaller key wins.
        if (in_ts > st_ts) begin
          outcome = sktu_pkg::OUT_REPLACED;
          we      = 1'b1;
        end else if (in_ts < st_ts) begin
          outcome = sktu_pkg::OUT_REJECTED;
        end else if (in_key < st_key) begin
          outcome = sktu_pkg::OUT_REPLACED;
          we      = 1'b1;
        end else if (in_key > st_key) begin
          outcome = sktu_pkg::OUT_KEPT_TIE;
        end else begin
          outcome = sktu_pkg::OUT_DUPLICATE;
        end
      end
      default: begin
        outcome = sktu_pkg::OUT_FULL;
      end
    endcase
  end

  // Outputs
  always_comb begin
    pop           = (state_r == sktu_pkg::B_IDLE) && !q_stat.empty;
    back_busy     = (state_r != sktu_pkg::B_IDLE);
    slot_wide     = {{SW{1'b0}}, cur_slot_r};
    out_valid_nxt = (state_r == sktu_pkg::B_EVAL);
    out_data_nxt.outcome = outcome;
    out_data_nxt.slot    = (outcome == sktu_pkg::OUT_FULL) ? '0 : slot_wide[SW-1:0];
    out_valid     = out_valid_r;
    out_data      = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sktu_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      cur_r      <= head_entry;
      cur_slot_r <= head_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sktu_pkg::B_EVAL && we) ent_mem[cur_slot_r] <= wr_data;
    if (pop) ent_q_r <= ent_mem[head_slot];
  end

`ifndef SYNTHESIS
  a_strobe_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == sktu_pkg::B_EVAL)
    else $error("result strobe without an evaluation cycle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two result strobes in a row");
`endif

endmodule

@@ design/session_key_table_upsert_top.sv @@
// Throughput: one request at a time; the search reads one host id per cycle from its
// memory, so the interval between requests is set by the fill count and the match slot.
// The result is a single-cycle strobe and the receiver cannot stall; the next start is
// taken in the cycle the result is shown. Reset clears the fill count and all control.
// ----------------------------------------------------------------------------
// Session key table upsert
// Searches a table of session entries by host and appends, replaces or
// rejects the offered entry, one result per request.
// ----------------------------------------------------------------------------
module session_key_table_upsert_top #(
  parameter int TABLE_ENTRIES = sktu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sktu_pkg::in_req_t  in_data,
  output logic               out_valid,
  output sktu_pkg::out_res_t out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  sktu_pkg::q_stat_t  q_stat;
  sktu_pkg::q_entry_t push_entry, head_entry;
  logic [AW-1:0]      push_slot, head_slot;
  logic               push, pop, front_busy, back_busy, accept;

  assign busy   = front_busy || !q_stat.empty || back_busy;
  assign accept = start && !busy;

  sktu_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_req     (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry),
    .push_slot  (push_slot),
    .front_busy (front_busy)
  );

  sktu_queue #(.AW(AW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_slot  (push_slot),
    .pop        (pop),
    .head_entry (head_entry),
    .head_slot  (head_slot),
    .q_stat     (q_stat)
  );

  sktu_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_entry (head_entry),
    .head_slot  (head_slot),
    .pop        (pop),
    .back_busy  (back_busy),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session key table upsert testbench
// Sends directed and random session entries into the table. A local copy of
// the table predicts the outcome and slot of every request, and each result
// strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          TBL_N     = sktu_pkg::TABLE_ENTRIES_DEF;
  localparam int          SLOT_BITS = sktu_pkg::SLOT_W;
  localparam int          N_RANDOM  = 1650;
  localparam logic [63:0] KEY_ONES  = '1;
  localparam logic [31:0] SEC_MAX   = '1;

  logic               clk;
  logic               rst_n;
  logic               start = 1'b0;
  logic               busy;
  sktu_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  sktu_pkg::out_res_t out_data;

  sktu_pkg::in_req_t  request_queue[$];
  sktu_pkg::out_res_t expected_outcomes[$];
  int                 requests_sent = 0;
  int                 errors = 0;

  // Predicted table contents; stamp and key are kept as one wide value each,
  // so a plain unsigned compare gives the field-by-field ordering.
  logic [15:0]  tbl_host  [TBL_N];
  logic [51:0]  tbl_stamp [TBL_N];
  logic [127:0] tbl_key   [TBL_N];
  int           tbl_fill = 0;

  // What the stimulus side believes is stored for each host it has placed.
  logic [15:0]  known_host[$];
  logic [51:0]  known_stamp[$];
  logic [127:0] known_key[$];

  session_key_table_upsert_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic sktu_pkg::out_res_t predict_upsert(sktu_pkg::in_req_t r);
    sktu_pkg::out_res_t res;
    logic [51:0]        st;
    logic [127:0]       k;
    st = {r.stamp_seconds, r.stamp_micros};
    k = {r.key_upper, r.key_lower};
    res.outcome = sktu_pkg::OUT_FULL;
    res.slot = '0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (tbl_host[i] == r.host) begin
        res.slot = SLOT_BITS'(i);
        if (st > tbl_stamp[i] || (st == tbl_stamp[i] && k < tbl_key[i])) begin
          tbl_stamp[i] = st;
          tbl_key[i] = k;
          res.outcome = sktu_pkg::OUT_REPLACED;
        end else if (st < tbl_stamp[i]) begin
          res.outcome = sktu_pkg::OUT_REJECTED;
        end else if (k > tbl_key[i]) begin
          res.outcome = sktu_pkg::OUT_KEPT_TIE;
        end else begin
          res.outcome = sktu_pkg::OUT_DUPLICATE;
        end
        return res;
      end
    end
    if (tbl_fill < TBL_N) begin
      res.slot = SLOT_BITS'(tbl_fill);
      res.outcome = sktu_pkg::OUT_APPENDED;
      tbl_host[tbl_fill] = r.host;
      tbl_stamp[tbl_fill] = st;
      tbl_key[tbl_fill] = k;
      tbl_fill++;
    end
    return res;
  endfunction

  function automatic int host_index(logic [15:0] h);
    for (int i = 0; i < known_host.size(); i++) begin
      if (known_host[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic logic [51:0] rand52();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[51:0];
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic sktu_pkg::in_req_t mk(logic [15:0] h, logic [31:0] sec,
                                           logic [19:0] us, logic [63:0] ku,
                                           logic [63:0] kl);
    sktu_pkg::in_req_t r;
    r.host = h;
    r.stamp_seconds = sec;
    r.stamp_micros = us;
    r.key_upper = ku;
    r.key_lower = kl;
    return r;
  endfunction

  task automatic offer_request(sktu_pkg::in_req_t r);
    if (host_index(r.host) < 0 && known_host.size() < TBL_N) begin
      known_host.push_back(r.host);
      known_stamp.push_back({r.stamp_seconds, r.stamp_micros});
      known_key.push_back({r.key_upper, r.key_lower});
    end
    request_queue.push_back(r);
  endtask

  // Most requests revisit a host already in the table with a stamp and key
  // placed above, below or equal to what is stored there.
  task automatic make_random_request();
    sktu_pkg::in_req_t r;
    logic [51:0]       st;
    logic [51:0]       d;
    logic [127:0]      k;
    logic [127:0]      kd;
    int                idx;
    int                pick;
    bit                track;
    pick = $urandom_range(0, 99);
    track = 1'b0;
    idx = -1;
    st = rand52();
    k = rand128();
    if ($urandom_range(0, 15) == 0) st = $urandom_range(0, 1) ? '0 : '1;
    if ($urandom_range(0, 15) == 0) k = $urandom_range(0, 1) ? '0 : '1;
    if (pick < 8 || known_host.size() == 0) begin
      r.host = $urandom_range(0, 65535);
    end else if (pick < 20) begin
      do r.host = $urandom_range(0, 65535); while (host_index(r.host) >= 0);
    end else begin
      idx = $urandom_range(0, known_host.size() - 1);
      r.host = known_host[idx];
      d = rand52() >> $urandom_range(0, 51);
      if (d == '0) d = 52'd1;
      kd = rand128() >> $urandom_range(0, 127);
      if (kd == '0) kd = 128'd1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (d <= ~known_stamp[idx]) begin
            st = known_stamp[idx] + d;
            track = 1'b1;
          end
        end
        4: begin
          st = known_stamp[idx] - d;
        end
        5: begin
          st = known_stamp[idx];
          k = known_key[idx];
        end
        6, 7: begin
          st = known_stamp[idx];
          k = known_key[idx];
          if (kd <= k) begin
            k = k - kd;
            track = 1'b1;
          end
        end
        default: begin
          st = known_stamp[idx];
          k = known_key[idx];
          if (kd <= ~k) k = k + kd;
        end
      endcase
    end
    r.stamp_seconds = st[51:20];
    r.stamp_micros = st[19:0];
    r.key_upper = k[127:64];
    r.key_lower = k[63:0];
    if (track) begin
      known_stamp[idx] = st;
      known_key[idx] = k;
    end
    offer_request(r);
  endtask

  // Requests are presented from the queue in order; start also drops at random
  // outside requests 600 to 899, so gaps land in every phase.
  always @(posedge clk) begin
    bit quiet;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(predict_upsert(in_data));
        void'(request_queue.pop_front());
        requests_sent++;
      end
      quiet = !(requests_sent >= 600 && requests_sent < 900) && ($urandom_range(0, 99) < 9);
      if (request_queue.size() != 0 && !quiet) begin
        start <= 1'b1;
        in_data <= request_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sktu_pkg::out_res_t exp;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual outcome %0d slot %0d",
                 $time, out_data.outcome, out_data.slot);
      end else begin
        exp = expected_outcomes.pop_front();
        if (out_data.outcome !== exp.outcome) begin
          errors++;
          $display("%0t: outcome mismatch, expected %0d, actual %0d",
                   $time, exp.outcome, out_data.outcome);
        end
        if (out_data.slot !== exp.slot) begin
          errors++;
          $display("%0t: slot mismatch, expected %0d, actual %0d",
                   $time, exp.slot, out_data.slot);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;

    // Extremes of every field, each outcome except full, and out-of-range micros that
    // still compare as plain numbers.
    offer_request(mk(16'h0000, 32'h0, 20'h0, 64'h0, 64'h0));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'hF_FFFF, KEY_ONES, KEY_ONES));
    offer_request(mk(16'h0000, 32'h0, 20'h0, 64'h0, 64'h0));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'hF_FFFF, KEY_ONES, KEY_ONES - 64'd1));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'hF_FFFF, KEY_ONES, KEY_ONES));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'hF_FFFF, KEY_ONES - 64'd1, 64'h0));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'hF_FFFF, KEY_ONES, 64'h0));
    offer_request(mk(16'hFFFF, SEC_MAX, 20'd999999, 64'h0, 64'h0));
    offer_request(mk(16'hFFFF, SEC_MAX - 32'd1, 20'hF_FFFF, 64'h0, 64'h0));
    offer_request(mk(16'h0000, 32'h0, 20'h1, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A));
    offer_request(mk(16'h0000, 32'h1, 20'h0, 64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5));
    offer_request(mk(16'h0000, 32'h0, 20'hF_FFFF, 64'h0, 64'h0));
    offer_request(mk(16'hA5A5, 32'h8000_0000, 20'd1000000, 64'h0123_4567_89AB_CDEF,
                     64'hFEDC_BA98_7654_3210));
    offer_request(mk(16'hA5A5, 32'h8000_0000, 20'd999999, 64'h0, 64'h0));
    offer_request(mk(16'hA5A5, 32'h8000_0000, 20'hF_FFFF, 64'h0123_4567_89AB_CDEF,
                     64'hFEDC_BA98_7654_3210));
    offer_request(mk(16'hA5A5, 32'h8000_0000, 20'hF_FFFF, 64'h0123_4567_89AB_CDEF,
                     64'hFEDC_BA98_7654_3210));
    offer_request(mk(16'h5A5A, 32'h7FFF_FFFF, 20'h5_5555, 64'h8000_0000_0000_0000, 64'h1));
    repeat (N_RANDOM) make_random_request();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (request_queue.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (TBL_N + 8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ session_key_table_upsert_top.f @@
design/sktu_pkg.sv
design/sktu_front.sv
design/sktu_queue.sv
design/sktu_back.sv
design/session_key_table_upsert_top.sv
bench/tb_top.sv
